// File: hw/rtl/oti_pkg.sv
// ----------------------------------------------------------------------------
// oti_pkg
// Shared constants and types for the opacity table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package oti_pkg;
  localparam int ValW = 48;
  localparam int TableEntriesDef = 64;
  localparam int UsedW = 7;
  localparam int AlbW = 17;
  // 2.99792458e11 * 2^24
  localparam logic [95:0] LambdaNum = 96'd299792458000 << 24;
  localparam logic [ValW-1:0] Mask48 = {ValW{1'b1}};

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_INTERP  = 2'd1,
    ST_LOW     = 2'd2,
    ST_HIGH    = 2'd3
  } status_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic start;
    logic [6:0] nbits;
  } div_ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/opacity_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// opacity_table_interpolator_unit
// Table of wavelength points with absorption and scattering opacities;
// queries convert frequency to wavelength, search, interpolate or clamp,
// and return the opacities and the albedo.
// ----------------------------------------------------------------------------
//  channel | direction | handshake    | payload
//  in      | input     | valid/stall  | cmd, entry_*, frequency_khz
//  out     | output    | valid/stall  | status, absorption, scattering, ...
//  cfg     | input     | valid/ready  | cfg_data (entries_used)
// A write returns its result the cycle after it is taken; the next
// transaction is taken once that result has left the output register.
// A query uses up to four 96-step divisions (wavelength, two interpolations,
// albedo) on one shared divider, up to 6 search steps on the single table
// read port, and four 24x24 multiply-accumulate steps per product; a
// clamped query skips the two interpolation divisions.
// Reset is synchronous; the tables are undefined until written.
// The next item is taken once the sequencer is idle and the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module opacity_table_interpolator_unit #(
  parameter int TABLE_ENTRIES = oti_pkg::TableEntriesDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic cmd,
  input  wire logic [5:0] entry_index,
  input  wire logic [47:0] entry_wavelength,
  input  wire logic [47:0] entry_absorption,
  input  wire logic [47:0] entry_scattering,
  input  wire logic [47:0] frequency_khz,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] status,
  output logic [47:0] absorption,
  output logic [47:0] scattering,
  output logic [16:0] albedo_value,
  output logic [5:0] segment_index,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [6:0] cfg_data
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_LDIV, S_LWAIT, S_RD0, S_RDN, S_CHK, S_SRCH, S_SWAIT, S_SCMP,
    S_RDSEG, S_RDSEG1, S_SETUP, S_MUL, S_MADD, S_IDIV, S_IWAIT, S_ADIV,
    S_AWAIT, S_OUT, S_CLAMP
  } state_t;

  logic [47:0] wmem [TABLE_ENTRIES];
  logic [47:0] amem [TABLE_ENTRIES];
  logic [47:0] smem [TABLE_ENTRIES];
  logic [AW-1:0] raddr;
  logic [47:0] rw, ra, rs;

  state_t state;
  logic [6:0] used_reg;
  logic [NW-1:0] n;
  logic [47:0] lam, w0, v0a, v0s, d, t, res_a;
  logic [AW-1:0] lo, hi, mid;
  logic pass;
  logic [1:0] st;
  logic [95:0] acc;
  logic [1:0] mstep;
  logic [47:0] mx, my;
  logic [2:0] pidx;
  logic [63:0] pprod;
  oti_pkg::div_ctl_t dctl;
  logic [95:0] dnum;
  logic [48:0] dden, dquo;
  logic dbusy;
  logic [AW:0] midsum;
  logic [48:0] tot;

  oti_divider u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dquo)
  );

  always_comb begin
    if (used_reg < 7'd2) n = NW'(2);
    else if ({25'd0, used_reg} > 32'(TABLE_ENTRIES)) n = NW'(TABLE_ENTRIES);
    else n = NW'(used_reg);
  end

  assign in_stall = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;
  assign midsum = {1'b0, lo} + {1'b0, hi} + 1'b1;
  assign tot = {1'b0, absorption} + {1'b0, scattering};
  // 24-bit limbs for partial products: pidx picks (x limb, y limb)
  assign pprod = {8'd0, (pidx[0] ? mx[47:24] : mx[23:0])} *
                 {40'd0, (pidx[1] ? my[47:24] : my[23:0])};

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && cmd == oti_pkg::CMD_WRITE &&
        {26'd0, entry_index} < 32'(TABLE_ENTRIES)) begin
      wmem[entry_index[AW-1:0]] <= entry_wavelength;
      amem[entry_index[AW-1:0]] <= entry_absorption;
      smem[entry_index[AW-1:0]] <= entry_scattering;
    end
    rw <= wmem[raddr];
    ra <= amem[raddr];
    rs <= smem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      used_reg <= 7'd64;
      dctl <= '0;
    end else begin
      if (dctl.start) dctl.start <= 1'b0;
      if (cfg_valid && cfg_ready) used_reg <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (cmd == oti_pkg::CMD_WRITE) begin
              status <= oti_pkg::ST_WRITTEN;
              absorption <= '0;
              scattering <= '0;
              albedo_value <= '0;
              segment_index <= '0;
              out_valid <= 1'b1;
            end else if (frequency_khz <= oti_pkg::LambdaNum[95:48]) begin
              // zero or low frequency: wavelength saturates
              lam <= oti_pkg::Mask48;
              state <= S_RD0;
            end else begin
              dnum <= oti_pkg::LambdaNum;
              dden <= {1'b0, frequency_khz};
              dctl <= '{start: 1'b1, nbits: 7'd96};
              state <= S_LDIV;
            end
          end
        end
        S_LDIV: state <= S_LWAIT;
        S_LWAIT: begin
          if (!dbusy) begin
            // quotient above 48 bits saturates
            lam <= dquo[48] ? oti_pkg::Mask48 : dquo[47:0];
            state <= S_RD0;
          end
        end
        S_RD0: begin
          raddr <= '0;
          pass <= 1'b0;
          state <= S_RDN;
        end
        S_RDN: begin
          raddr <= AW'(n - 1'b1);
          state <= S_CHK;
        end
        S_CHK: begin
          // rw holds entry 0 here; next cycle it holds entry n-1
          if (!pass) begin
            pass <= 1'b1;
            if (lam <= rw) begin
              st <= oti_pkg::ST_LOW;
              segment_index <= '0;
              res_a <= ra;
              scattering <= rs;
              state <= S_CLAMP;
            end
          end else begin
            pass <= 1'b0;
            if (lam >= rw) begin
              st <= oti_pkg::ST_HIGH;
              segment_index <= 6'(n - 1'b1);
              res_a <= ra;
              scattering <= rs;
              state <= S_CLAMP;
            end else begin
              lo <= '0;
              hi <= AW'(n - 2'd2);
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid <= midsum[AW:1];
            raddr <= midsum[AW:1];
            state <= S_SWAIT;
          end else begin
            raddr <= lo;
            segment_index <= 6'(lo);
            st <= oti_pkg::ST_INTERP;
            state <= S_RDSEG;
          end
        end
        S_SWAIT: state <= S_SCMP;
        S_SCMP: begin
          if (rw <= lam) lo <= mid;
          else hi <= mid - 1'b1;
          state <= S_SRCH;
        end
        S_RDSEG: begin
          raddr <= lo + 1'b1;
          state <= S_RDSEG1;
        end
        S_RDSEG1: begin
          w0 <= rw;
          v0a <= ra;
          v0s <= rs;
          state <= S_SETUP;
        end
        S_SETUP: begin
          if (rw <= w0) begin
            res_a <= v0a;
            scattering <= v0s;
            state <= S_CLAMP;
          end else begin
            d <= rw - w0;
            t <= (lam - w0 > rw - w0) ? rw - w0 : lam - w0;
            mx <= ra;
            state <= S_MUL;
            mstep <= 2'd0;
            pass <= 1'b0;
            acc <= '0;
            pidx <= '0;
          end
        end
        S_MUL: begin
          // first pass: v1*t; second: v0*(d-t)
          my <= mstep[0] ? (d - t) : t;
          pidx <= '0;
          state <= S_MADD;
        end
        S_MADD: begin
          acc <= acc + ({32'd0, pprod} << (24 * (32'(pidx[0]) + 32'(pidx[1]))));
          if (pidx == 3'd3) begin
            if (!mstep[0]) begin
              mstep <= 2'd1;
              mx <= pass ? v0s : v0a;
              state <= S_MUL;
            end else begin
              state <= S_IDIV;
            end
          end
          pidx <= pidx + 3'd1;
        end
        S_IDIV: begin
          dnum <= acc;
          dden <= {1'b0, d};
          dctl <= '{start: 1'b1, nbits: 7'd96};
          state <= S_IWAIT;
        end
        S_IWAIT: begin
          if (!dctl.start && !dbusy) begin
            if (!pass) begin
              res_a <= dquo[47:0];
              pass <= 1'b1;
              mx <= rs;
              acc <= '0;
              mstep <= 2'd0;
              state <= S_MUL;
            end else begin
              pass <= 1'b0;
              scattering <= dquo[47:0];
              state <= S_CLAMP;
            end
          end
        end
        S_CLAMP: begin
          absorption <= res_a;
          status <= st;
          state <= S_ADIV;
        end
        S_ADIV: begin
          if (tot == '0) begin
            albedo_value <= '0;
            state <= S_OUT;
          end else begin
            dnum <= {scattering, 48'd0} >> 32;
            dden <= tot;
            dctl <= '{start: 1'b1, nbits: 7'd96};
            state <= S_AWAIT;
          end
        end
        S_AWAIT: begin
          if (!dctl.start && !dbusy) begin
            albedo_value <= dquo[16:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/oti_divider.sv
// ----------------------------------------------------------------------------
// oti_divider
// Restoring divider, one quotient bit per cycle, top nbits of a 96-bit
// dividend shifted in MSB first. Quotient truncated to 49 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module oti_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire oti_pkg::div_ctl_t ctl,
  input  wire logic [95:0] num,
  input  wire logic [48:0] den,
  output logic busy,
  output logic [48:0] quo
);
  logic [95:0] sh;
  logic [49:0] rem;
  logic [6:0] cnt;
  logic [49:0] trial;

  always_comb begin
    trial = {rem[48:0], sh[95]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt <= ctl.nbits;
      sh <= num;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      sh <= {sh[94:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[47:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[47:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/oti_checker.sv
// ----------------------------------------------------------------------------
// oti_checker
// Port-level checks for the opacity table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
module oti_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [1:0] status,
  input wire logic [16:0] albedo_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_alb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> albedo_value <= 17'd65536)
    else $error("albedo out of range");
  a_wr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == oti_pkg::ST_WRITTEN |-> albedo_value == '0)
    else $error("write result nonzero");
endmodule
bind opacity_table_interpolator_unit oti_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .albedo_value(albedo_value)
);
`default_nettype wire
